FILE: src/scan_sector_heading_adjuster_top_defines.svh
// Assertion macros shared by the checker of the scan sector heading adjuster.
// Expects signals named clock and reset in the scope where a macro is used.
`ifndef SCAN_SECTOR_HEADING_ADJUSTER_TOP_DEFINES_SVH
`define SCAN_SECTOR_HEADING_ADJUSTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SSHA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ssha checker: same-cycle rule violated");

// Next-cycle implication, disabled during reset.
`define SSHA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ssha checker: next-cycle rule violated");

`endif

FILE: src/ssha_pkg.sv
// Package of the scan sector heading adjuster: field widths, register codes,
// reset values and the structs passed between the stages. No dependencies.
package ssha_pkg;

   localparam int MAX_SAMPLES_DEF = 1024;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [16:0] KEY_MAX     = 17'h10000;
   localparam logic [31:0] ONE_DEG_Q16 = 32'd1143;
   // Reciprocal of ten for a shift of 26, exact for every nine-fold dodge angle.
   localparam logic [22:0] RECIP_TEN   = 23'd6710887;

   localparam logic [15:0] RANGE_FLOOR_RST = 16'd0;
   localparam logic [15:0] NEAR_THR_RST    = 16'd102;
   localparam logic [17:0] DODGE_RST       = 18'd19661;
   localparam logic [17:0] UNDO_RST        = 18'd17694;
   localparam logic [15:0] GYRO_PERIOD_RST = 16'd6554;
   localparam logic [9:0]  RIGHT_FIRST_RST = 10'd128;
   localparam logic [10:0] RIGHT_STOP_RST  = 11'd483;
   localparam logic [9:0]  LEFT_FIRST_RST  = 10'd540;
   localparam logic [10:0] LEFT_STOP_RST   = 11'd896;

   typedef enum logic [1:0] {
      OP_RANGE = 2'd0,
      OP_GYRO  = 2'd1,
      OP_TURN  = 2'd2,
      OP_STOP  = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE_FLOOR = 3'd0,
      CSR_NEAR_THR    = 3'd1,
      CSR_DODGE       = 3'd2,
      CSR_GYRO_PERIOD = 3'd3,
      CSR_RIGHT_FIRST = 3'd4,
      CSR_RIGHT_STOP  = 3'd5,
      CSR_LEFT_FIRST  = 3'd6,
      CSR_LEFT_STOP   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [15:0] range_floor;
      logic [15:0] near_threshold;
      logic [17:0] dodge_angle;
      logic [17:0] undo_angle;
      logic [15:0] gyro_period;
      logic [9:0]  right_first;
      logic [10:0] right_stop;
      logic [9:0]  left_first;
      logic [10:0] left_stop;
   } cfg_type;

   // One accepted beat after the front stage has done its precomputation.
   typedef struct packed {
      opcode_type   opcode;
      logic [15:0]  raw;
      logic [16:0]  key;
      logic         scan_end;
      logic [20:0]  delta;
      logic [31:0]  turn_amount;
      logic         stop_request;
      logic         in_right;
      logic         first_right;
      logic         in_left;
      logic         first_left;
   } item_type;

endpackage

FILE: src/scan_sector_heading_adjuster_top.sv
// Top level of the scan sector heading adjuster: configuration registers, the
// input stage and the state stage. Depends on ssha_pkg and the ssha_* modules.
//
// The block takes one beat per clock cycle while the result side is not stalled:
// range samples, gyro samples, turn commands and stop commands may follow each
// other in every cycle, and each accepted beat gives exactly one result beat.
// The input stage registers the beat together with its range key, its rounded
// gyro delta (one of the two multipliers of the design) and whether its sample
// index falls in the right or left sector; the state stage then updates the
// sector minima, the dodge and turn state and the heading, and loads the result
// register. A stalled result register stops the state stage, and the input
// register still takes one more beat behind it, so back-pressure reaches
// req_tready only once the input register is full. Configuration writes take
// effect at the next edge and should be made only while no beat is in flight.
module scan_sector_heading_adjuster_top
   import ssha_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: range_sample[15:0], yaw_rate[31:16], turn_amount[63:32],
   // stop_request[64], zero fill up to bit 71.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: opcode[1:0].
   input  logic [1:0]            req_tuser,
   // scan_end: last range sample of a scan.
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: heading_goal[31:0], turning[32], turn_complete[33],
   // dodging_right_side[34], dodging_left_side[35], halted[36], zero fill to 39.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg;
   item_type item;
   logic     item_valid;
   logic     core_ready;

   // Register file; the undo angle is derived when the dodge angle is written.
   ssha_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register with the sample counter of the running scan.
   ssha_front #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .core_ready (core_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   // State update and result register.
   ssha_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .core_ready (core_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: src/ssha_csr.sv
// Configuration registers of the scan sector heading adjuster, including the
// precomputed nine-tenths undo angle. Depends on ssha_pkg.
module ssha_csr
   import ssha_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type     cfg_ff, cfg_in;
   logic [21:0] nine_x;
   logic [44:0] undo_prod;

   assign nine_x    = {1'b0, csr_wdata, 3'b000} + {4'b0000, csr_wdata};
   assign undo_prod = 45'(nine_x) * 45'(RECIP_TEN);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_RANGE_FLOOR: cfg_in.range_floor    = csr_wdata[15:0];
            CSR_NEAR_THR:    cfg_in.near_threshold = csr_wdata[15:0];
            CSR_DODGE: begin
               cfg_in.dodge_angle = csr_wdata;
               cfg_in.undo_angle  = undo_prod[43:26];
            end
            CSR_GYRO_PERIOD: cfg_in.gyro_period    = csr_wdata[15:0];
            CSR_RIGHT_FIRST: cfg_in.right_first    = csr_wdata[9:0];
            CSR_RIGHT_STOP:  cfg_in.right_stop     = csr_wdata[10:0];
            CSR_LEFT_FIRST:  cfg_in.left_first     = csr_wdata[9:0];
            CSR_LEFT_STOP:   cfg_in.left_stop      = csr_wdata[10:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_floor    <= RANGE_FLOOR_RST;
         cfg_ff.near_threshold <= NEAR_THR_RST;
         cfg_ff.dodge_angle    <= DODGE_RST;
         cfg_ff.undo_angle     <= UNDO_RST;
         cfg_ff.gyro_period    <= GYRO_PERIOD_RST;
         cfg_ff.right_first    <= RIGHT_FIRST_RST;
         cfg_ff.right_stop     <= RIGHT_STOP_RST;
         cfg_ff.left_first     <= LEFT_FIRST_RST;
         cfg_ff.left_stop      <= LEFT_STOP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/ssha_front.sv
// Input stage of the scan sector heading adjuster: registers each beat with its
// range key, gyro delta and sector membership. Depends on ssha_pkg.
module ssha_front
   import ssha_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  req_tlast,
   input  logic                  core_ready,
   output logic                  item_valid,
   output item_type              item
);

   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int CMPW = (CW > 11) ? CW : 11;

   logic            valid_ff, valid_in;
   item_type        item_ff, item_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            accept, live;
   logic [CMPW-1:0] idx, r_first, r_stop, l_first, l_stop;
   logic [15:0]     raw;
   logic signed [15:0] yaw;
   logic signed [32:0] prod;
   logic signed [32:0] rounded;

   assign req_tready = !valid_ff || core_ready;
   assign accept     = req_tvalid && req_tready;

   assign raw  = req_tdata[15:0];
   assign yaw  = $signed(req_tdata[31:16]);
   assign prod = 33'(yaw) * 33'($signed({1'b0, cfg.gyro_period}));
   assign rounded = prod + 33'sd2048;

   assign live    = count_ff < CW'(MAX_SAMPLES);
   assign idx     = CMPW'(count_ff);
   assign r_first = CMPW'(cfg.right_first);
   assign r_stop  = CMPW'(cfg.right_stop);
   assign l_first = CMPW'(cfg.left_first);
   assign l_stop  = CMPW'(cfg.left_stop);

   always_comb begin
      item_in.opcode       = opcode_type'(req_tuser);
      item_in.raw          = raw;
      item_in.key          = (raw <= cfg.range_floor) ? KEY_MAX : {1'b0, raw};
      item_in.scan_end     = req_tlast;
      item_in.delta        = rounded[32:12];
      item_in.turn_amount  = req_tdata[63:32];
      item_in.stop_request = req_tdata[64];
      item_in.in_right     = live && (idx >= r_first) && (idx < r_stop);
      item_in.first_right  = idx == r_first;
      item_in.in_left      = live && (idx >= l_first) && (idx < l_stop);
      item_in.first_left   = idx == l_first;
   end

   always_comb begin
      count_in = count_ff;
      if (accept && (opcode_type'(req_tuser) == OP_RANGE)) begin
         if (req_tlast) begin
            count_in = '0;
         end else if (live) begin
            count_in = count_ff + CW'(1);
         end
      end
      valid_in = accept ? 1'b1 : (core_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: src/ssha_core.sv
// State stage of the scan sector heading adjuster: sector minima, dodge and
// turn state, heading, and the result register. Depends on ssha_pkg.
module ssha_core
   import ssha_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  item_valid,
   input  item_type              item,
   output logic                  core_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [31:0] heading_ff, heading_in;
   logic [31:0] left_over_ff, left_over_in;
   logic        turn_ff, turn_in, halt_ff, halt_in;
   logic        rdodge_ff, rdodge_in, ldodge_ff, ldodge_in;
   logic [16:0] rkey_ff, rkey_in, lkey_ff, lkey_in;
   logic [15:0] rraw_ff, rraw_in, lraw_ff, lraw_in;
   logic        rseen_ff, rseen_in, lseen_ff, lseen_in;
   logic        complete, fire;
   logic        take_r, take_l, hit_r, hit_l;
   logic [16:0] dist_r, dist_l, thr;
   logic signed [32:0] gyro_sum, turn_sum;
   logic signed [31:0] gyro_left, turn_sat;

   assign core_ready = !rsp_valid_ff || rsp_tready;
   assign fire       = item_valid && core_ready;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      if (v[32] != v[31]) begin
         sat32 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   assign gyro_sum  = $signed({left_over_ff[31], left_over_ff})
                    - 33'(signed'(item.delta));
   assign gyro_left = sat32(gyro_sum);
   assign turn_sum  = $signed({left_over_ff[31], left_over_ff})
                    + $signed({item.turn_amount[31], item.turn_amount});
   assign turn_sat  = sat32(turn_sum);

   // Minimum search including the current sample, then the end-of-scan decision.
   assign take_r = item.in_right && (item.first_right || (item.key < rkey_ff));
   assign take_l = item.in_left && (item.first_left || (item.key < lkey_ff));
   assign thr    = {1'b0, cfg.near_threshold};

   always_comb begin
      rkey_in  = take_r ? item.key : rkey_ff;
      rraw_in  = take_r ? item.raw : rraw_ff;
      rseen_in = rseen_ff || take_r;
      lkey_in  = take_l ? item.key : lkey_ff;
      lraw_in  = take_l ? item.raw : lraw_ff;
      lseen_in = lseen_ff || take_l;
      dist_r   = rseen_in ? {1'b0, rraw_in} : KEY_MAX;
      dist_l   = lseen_in ? {1'b0, lraw_in} : KEY_MAX;
      hit_r    = (dist_r <= thr) && (dist_r < dist_l);
      hit_l    = (dist_l <= thr) && (dist_l < dist_r);
   end

   always_comb begin
      heading_in   = heading_ff;
      left_over_in = left_over_ff;
      turn_in      = turn_ff;
      halt_in      = halt_ff;
      rdodge_in    = rdodge_ff;
      ldodge_in    = ldodge_ff;
      complete     = 1'b0;
      case (item.opcode)
         OP_RANGE: begin
            if (item.scan_end) begin
               if (hit_r) begin
                  if (!rdodge_ff) begin
                     rdodge_in  = 1'b1;
                     heading_in = heading_ff - {14'd0, cfg.dodge_angle};
                  end
               end else if (hit_l) begin
                  if (!ldodge_ff) begin
                     ldodge_in  = 1'b1;
                     heading_in = heading_ff + {14'd0, cfg.dodge_angle};
                  end
               end else if (rdodge_ff) begin
                  rdodge_in  = 1'b0;
                  heading_in = heading_ff + {14'd0, cfg.undo_angle};
               end else if (ldodge_ff) begin
                  ldodge_in  = 1'b0;
                  heading_in = heading_ff - {14'd0, cfg.undo_angle};
               end
            end
         end
         OP_GYRO: begin
            if (!halt_ff && turn_ff) begin
               if ((gyro_left <= $signed(ONE_DEG_Q16)) &&
                   (gyro_left >= -$signed(ONE_DEG_Q16))) begin
                  turn_in      = 1'b0;
                  complete     = 1'b1;
                  left_over_in = '0;
               end else begin
                  left_over_in = gyro_left;
               end
            end
         end
         OP_TURN: begin
            left_over_in = turn_sat;
            heading_in   = heading_ff - item.turn_amount;
            turn_in      = turn_sat != 32'sd0;
         end
         default: begin
            halt_in = item.stop_request;
         end
      endcase
      rsp_data_in = {3'b000, halt_in, ldodge_in, rdodge_in, complete, turn_in, heading_in};
      rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         heading_ff   <= '0;
         left_over_ff <= '0;
         turn_ff      <= 1'b0;
         halt_ff      <= 1'b1;
         rdodge_ff    <= 1'b0;
         ldodge_ff    <= 1'b0;
         rkey_ff      <= KEY_MAX;
         lkey_ff      <= KEY_MAX;
         rraw_ff      <= '0;
         lraw_ff      <= '0;
         rseen_ff     <= 1'b0;
         lseen_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            heading_ff   <= heading_in;
            left_over_ff <= left_over_in;
            turn_ff      <= turn_in;
            halt_ff      <= halt_in;
            rdodge_ff    <= rdodge_in;
            ldodge_ff    <= ldodge_in;
            if (item.opcode == OP_RANGE) begin
               if (item.scan_end) begin
                  rkey_ff  <= KEY_MAX;
                  lkey_ff  <= KEY_MAX;
                  rraw_ff  <= '0;
                  lraw_ff  <= '0;
                  rseen_ff <= 1'b0;
                  lseen_ff <= 1'b0;
               end else begin
                  rkey_ff  <= rkey_in;
                  lkey_ff  <= lkey_in;
                  rraw_ff  <= rraw_in;
                  lraw_ff  <= lraw_in;
                  rseen_ff <= rseen_in;
                  lseen_ff <= lseen_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: src/ssha_checker.sv
// Port-level checker of the scan sector heading adjuster, bound to the top
// level. Depends on ssha_pkg and scan_sector_heading_adjuster_top_defines.svh.
`include "scan_sector_heading_adjuster_top_defines.svh"

module ssha_checker
   import ssha_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [1:0]            req_tuser,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  csr_we,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   // A stalled result holds its beat.
   `SSHA_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // With no result waiting both stages can move, so the input side is open.
   `SSHA_ASSERT_IMP(a_ready_open, !rsp_tvalid, req_tready)
   // A finished turn is no longer turning and was not halted.
   `SSHA_ASSERT_IMP(a_done_idle, rsp_tvalid && rsp_tdata[33], !rsp_tdata[32] && !rsp_tdata[36])

endmodule

bind scan_sector_heading_adjuster_top ssha_checker u_ssha_checker (.*);
